// ----- hdl/yrg_pkg.sv -----
`default_nettype none
package yrg_pkg;

   localparam int PixW       = 8;
   localparam int StageCount = 4;
   localparam int SumW       = 20;
   localparam int DiffW      = 10;
   localparam int GraySumW   = 10;
   localparam int DivW       = 20;
   localparam int DivShift   = 11;

   localparam logic signed [SumW-1:0]  CoefLuma      = 20'sd298;
   localparam logic signed [SumW-1:0]  CoefBlueU     = 20'sd516;
   localparam logic signed [SumW-1:0]  CoefGreenU    = 20'sd100;
   localparam logic signed [SumW-1:0]  CoefGreenV    = 20'sd208;
   localparam logic signed [SumW-1:0]  CoefRedV      = 20'sd409;
   localparam logic signed [SumW-1:0]  RoundBias     = 20'sd128;
   localparam logic signed [DiffW-1:0] LumaOffset    = 10'sd16;
   localparam logic signed [DiffW-1:0] ChromaOffset  = 10'sd128;
   localparam logic signed [SumW-1:0]  PixMax        = 20'sd255;
   localparam logic [DivW-1:0]         DivThreeRecip = 20'd683;

   typedef logic [PixW-1:0] pix_type;

   typedef struct packed {
      logic [StageCount-1:0] load;
   } stage_ctl_type;

   function automatic pix_type clamp_shift(input logic signed [SumW-1:0] sum);
      logic signed [SumW-1:0] sh;
      sh = sum >>> PixW;
      if (sh < 0) begin
         return '0;
      end
      if (sh > PixMax) begin
         return '1;
      end
      return sh[PixW-1:0];
   endfunction

endpackage
`default_nettype wire

// ----- hdl/yrg_chan_if.sv -----
`default_nettype none
interface yrg_req_if import yrg_pkg::*; ();
   logic    valid;
   logic    ready;
   pix_type luma_first;
   pix_type chroma_blue;
   pix_type luma_second;
   pix_type chroma_red;
   logic    last_pair;

   modport source (output valid, luma_first, chroma_blue, luma_second, chroma_red,
                   last_pair, input ready);
   modport sink (input valid, luma_first, chroma_blue, luma_second, chroma_red,
                 last_pair, output ready);
endinterface

interface yrg_rsp_if import yrg_pkg::*; ();
   logic    valid;
   logic    ready;
   pix_type blue_first;
   pix_type green_first;
   pix_type red_first;
   pix_type blue_second;
   pix_type green_second;
   pix_type red_second;
   pix_type gray_first;
   pix_type gray_second;
   logic    last_out;

   modport source (output valid, blue_first, green_first, red_first, blue_second,
                   green_second, red_second, gray_first, gray_second, last_out,
                   input ready);
   modport sink (input valid, blue_first, green_first, red_first, blue_second,
                 green_second, red_second, gray_first, gray_second, last_out,
                 output ready);
endinterface
`default_nettype wire

// ----- hdl/yrg_pixel.sv -----
`default_nettype none
module yrg_pixel import yrg_pkg::*; (
   input  wire                     clock,
   input  stage_ctl_type           ctl,
   input  pix_type                 luma,
   input  wire logic signed [SumW-1:0] blue_u,
   input  wire logic signed [SumW-1:0] green_u,
   input  wire logic signed [SumW-1:0] green_v,
   input  wire logic signed [SumW-1:0] red_v,
   output pix_type                 blue,
   output pix_type                 green,
   output pix_type                 red,
   output pix_type                 gray
);

   logic signed [DiffW-1:0] c_in;
   logic signed [SumW-1:0]  luma_prod_in, luma_prod_ff;
   pix_type                 b2_in, g2_in, r2_in, b2_ff, g2_ff, r2_ff;
   pix_type                 b3_ff, g3_ff, r3_ff;
   logic [GraySumW-1:0]     sum3_in, sum3_ff;
   logic [DivW-1:0]         div_in;
   pix_type                 b4_ff, g4_ff, r4_ff, gray4_ff;

   assign c_in         = signed'({2'b00, luma}) - LumaOffset;
   assign luma_prod_in = SumW'(c_in) * CoefLuma;

   assign b2_in = clamp_shift(luma_prod_ff + blue_u + RoundBias);
   assign g2_in = clamp_shift(luma_prod_ff - green_u - green_v + RoundBias);
   assign r2_in = clamp_shift(luma_prod_ff + red_v + RoundBias);

   assign sum3_in = GraySumW'(b2_ff) + GraySumW'(g2_ff) + GraySumW'(r2_ff);
   assign div_in  = DivW'(sum3_ff) * DivThreeRecip;

   always_ff @(posedge clock) begin
      if (ctl.load[0]) begin
         luma_prod_ff <= luma_prod_in;
      end
      if (ctl.load[1]) begin
         b2_ff <= b2_in;
         g2_ff <= g2_in;
         r2_ff <= r2_in;
      end
      if (ctl.load[2]) begin
         b3_ff   <= b2_ff;
         g3_ff   <= g2_ff;
         r3_ff   <= r2_ff;
         sum3_ff <= sum3_in;
      end
      if (ctl.load[3]) begin
         b4_ff    <= b3_ff;
         g4_ff    <= g3_ff;
         r4_ff    <= r3_ff;
         gray4_ff <= div_in[DivShift +: PixW];
      end
   end

   assign blue  = b4_ff;
   assign green = g4_ff;
   assign red   = r4_ff;
   assign gray  = gray4_ff;

endmodule
`default_nettype wire

// ----- hdl/yuy2_to_rgb_and_gray.sv -----
// YUY2 to RGB and gray converter, BT.601 integer form. Each transaction on req_if
// carries one macropixel (two lumas sharing one U and one V); each transaction on
// rsp_if carries clamped blue, green and red for both pixels, a truncated mean of
// the three as gray for each, and the last-pair flag. One macropixel is taken every
// clock unless every stage is full and rsp_if.ready is low. Data pass through the
// constant-product, sum-and-clamp, gray-sum and divide-by-three register stages.
// A stage holds while its successor stalls, refills once empty; bubbles close up.
`default_nettype none
module yuy2_to_rgb_and_gray import yrg_pkg::*; (
   input wire      clock,
   input wire      reset,
   yrg_req_if.sink   req_if,
   yrg_rsp_if.source rsp_if
);

   logic [StageCount-1:0]   valid_ff, valid_in, stage_ready;
   stage_ctl_type           ctl;
   logic [StageCount-1:0]   last_ff;
   logic signed [DiffW-1:0] d_in, e_in;
   logic signed [SumW-1:0]  blue_u_ff, green_u_ff, green_v_ff, red_v_ff;

   always_comb begin
      stage_ready[StageCount-1] = !valid_ff[StageCount-1] || rsp_if.ready;
      for (int k = StageCount - 2; k >= 0; k--) begin
         stage_ready[k] = !valid_ff[k] || stage_ready[k+1];
      end
      ctl.load[0] = stage_ready[0] && req_if.valid;
      valid_in    = valid_ff;
      if (stage_ready[0]) begin
         valid_in[0] = req_if.valid;
      end
      for (int k = 1; k < StageCount; k++) begin
         ctl.load[k] = stage_ready[k] && valid_ff[k-1];
         if (stage_ready[k]) begin
            valid_in[k] = valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign d_in = signed'({2'b00, req_if.chroma_blue}) - ChromaOffset;
   assign e_in = signed'({2'b00, req_if.chroma_red}) - ChromaOffset;

   always_ff @(posedge clock) begin
      if (ctl.load[0]) begin
         blue_u_ff  <= SumW'(d_in) * CoefBlueU;
         green_u_ff <= SumW'(d_in) * CoefGreenU;
         green_v_ff <= SumW'(e_in) * CoefGreenV;
         red_v_ff   <= SumW'(e_in) * CoefRedV;
         last_ff[0] <= req_if.last_pair;
      end
      for (int k = 1; k < StageCount; k++) begin
         if (ctl.load[k]) begin
            last_ff[k] <= last_ff[k-1];
         end
      end
   end

   yrg_pixel u_pix_first (
      .clock   (clock),
      .ctl     (ctl),
      .luma    (req_if.luma_first),
      .blue_u  (blue_u_ff),
      .green_u (green_u_ff),
      .green_v (green_v_ff),
      .red_v   (red_v_ff),
      .blue    (rsp_if.blue_first),
      .green   (rsp_if.green_first),
      .red     (rsp_if.red_first),
      .gray    (rsp_if.gray_first)
   );

   yrg_pixel u_pix_second (
      .clock   (clock),
      .ctl     (ctl),
      .luma    (req_if.luma_second),
      .blue_u  (blue_u_ff),
      .green_u (green_u_ff),
      .green_v (green_v_ff),
      .red_v   (red_v_ff),
      .blue    (rsp_if.blue_second),
      .green   (rsp_if.green_second),
      .red     (rsp_if.red_second),
      .gray    (rsp_if.gray_second)
   );

   assign req_if.ready    = stage_ready[0];
   assign rsp_if.valid    = valid_ff[StageCount-1];
   assign rsp_if.last_out = last_ff[StageCount-1];

endmodule
`default_nettype wire

// ----- hdl/yrg_checker.sv -----
`default_nettype none
module yrg_checker import yrg_pkg::*; (
   input wire     clock,
   input wire     reset,
   input wire     req_valid,
   input wire     req_ready,
   input wire     rsp_valid,
   input wire     rsp_ready,
   input pix_type blue_first,
   input pix_type green_first,
   input pix_type red_first,
   input pix_type blue_second,
   input pix_type green_second,
   input pix_type red_second,
   input pix_type gray_first,
   input pix_type gray_second,
   input wire     last_out
);

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(blue_first) && $stable(green_first)
         && $stable(red_first) && $stable(blue_second) && $stable(green_second)
         && $stable(red_second) && $stable(gray_first) && $stable(gray_second)
         && $stable(last_out))
      else $error("response changed while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (gray_first <= blue_first || gray_first <= green_first
         || gray_first <= red_first)
         && (gray_first >= blue_first || gray_first >= green_first
         || gray_first >= red_first))
      else $error("first gray outside its colour range");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (gray_second <= blue_second || gray_second <= green_second
         || gray_second <= red_second)
         && (gray_second >= blue_second || gray_second >= green_second
         || gray_second >= red_second))
      else $error("second gray outside its colour range");

   assert property (@(posedge clock) disable iff (reset)
      $past(req_valid && req_ready, 4) && $past(rsp_ready, 1) && $past(rsp_ready, 2)
         && $past(rsp_ready, 3) && !$past(reset, 1) && !$past(reset, 2)
         && !$past(reset, 3) && !$past(reset, 4) |-> rsp_valid)
      else $error("transaction not delivered after four free-flowing clocks");

endmodule

bind yuy2_to_rgb_and_gray yrg_checker u_yrg_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_if.valid),
   .req_ready    (req_if.ready),
   .rsp_valid    (rsp_if.valid),
   .rsp_ready    (rsp_if.ready),
   .blue_first   (rsp_if.blue_first),
   .green_first  (rsp_if.green_first),
   .red_first    (rsp_if.red_first),
   .blue_second  (rsp_if.blue_second),
   .green_second (rsp_if.green_second),
   .red_second   (rsp_if.red_second),
   .gray_first   (rsp_if.gray_first),
   .gray_second  (rsp_if.gray_second),
   .last_out     (rsp_if.last_out)
);
`default_nettype wire

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
   import yrg_pkg::*;

   typedef struct packed {
      pix_type luma_first;
      pix_type chroma_blue;
      pix_type luma_second;
      pix_type chroma_red;
      logic    last_pair;
   } yuy2_pair_type;

   typedef struct packed {
      pix_type blue_first;
      pix_type green_first;
      pix_type red_first;
      pix_type blue_second;
      pix_type green_second;
      pix_type red_second;
      pix_type gray_first;
      pix_type gray_second;
      logic    last_out;
   } bgr_gray_type;

   localparam int CycleLimit  = 200000;
   localparam int HoldCycles  = 300;
   localparam int DrainCycles = 16;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   yuy2_pair_type req_pair = '0;
   logic          rsp_ready = 1'b0;

   int   sender_idle_pct = 0;
   int   receiver_stall_pct = 0;
   logic hold_request = 1'b0;
   logic long_hold = 1'b0;
   int   cycle_count = 0;
   int   fail_count = 0;

   yuy2_pair_type pending_pairs[$];
   bgr_gray_type  expected_pixels[$];

   yrg_req_if req_if ();
   yrg_rsp_if rsp_if ();

   assign req_if.valid       = req_valid;
   assign req_if.luma_first  = req_pair.luma_first;
   assign req_if.chroma_blue = req_pair.chroma_blue;
   assign req_if.luma_second = req_pair.luma_second;
   assign req_if.chroma_red  = req_pair.chroma_red;
   assign req_if.last_pair   = req_pair.last_pair;
   assign rsp_if.ready       = rsp_ready;

   yuy2_to_rgb_and_gray dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic pix_type saturate_byte(input int sum);
      int scaled;
      scaled = sum >>> 8;
      if (scaled < 0) begin
         return 8'd0;
      end
      if (scaled > 255) begin
         return 8'd255;
      end
      return pix_type'(scaled);
   endfunction

   function automatic void convert_pixel(input pix_type luma, input int d, input int e,
                                         output pix_type b, output pix_type g,
                                         output pix_type r, output pix_type gray);
      int c;
      int total;
      c = int'(luma) - 16;
      b = saturate_byte(298 * c + 516 * d + 128);
      g = saturate_byte(298 * c - 100 * d - 208 * e + 128);
      r = saturate_byte(298 * c + 409 * e + 128);
      total = int'(b) + int'(g) + int'(r);
      gray = pix_type'(total / 3);
   endfunction

   function automatic bgr_gray_type convert_pair(input yuy2_pair_type p);
      bgr_gray_type o;
      int d;
      int e;
      d = int'(p.chroma_blue) - 128;
      e = int'(p.chroma_red) - 128;
      convert_pixel(p.luma_first, d, e, o.blue_first, o.green_first, o.red_first,
                    o.gray_first);
      convert_pixel(p.luma_second, d, e, o.blue_second, o.green_second, o.red_second,
                    o.gray_second);
      o.last_out = p.last_pair;
      return o;
   endfunction

   function automatic pix_type random_byte();
      if ($urandom_range(7) == 0) begin
         return $urandom_range(1) ? 8'd255 : 8'd0;
      end
      return pix_type'($urandom_range(255));
   endfunction

   task automatic queue_random(input int count);
      yuy2_pair_type p;
      for (int i = 0; i < count; i++) begin
         p.luma_first  = random_byte();
         p.chroma_blue = random_byte();
         p.luma_second = random_byte();
         p.chroma_red  = random_byte();
         p.last_pair   = ($urandom_range(7) == 0);
         pending_pairs.push_back(p);
      end
   endtask

   task automatic queue_directed();
      pix_type       chroma[3] = '{8'd0, 8'd128, 8'd255};
      yuy2_pair_type p;
      for (int u = 0; u < 3; u++) begin
         for (int v = 0; v < 3; v++) begin
            p.luma_first  = ((u + v) % 2 == 0) ? 8'd0 : 8'd255;
            p.chroma_blue = chroma[u];
            p.luma_second = ((u + v) % 2 == 0) ? 8'd235 : 8'd16;
            p.chroma_red  = chroma[v];
            p.last_pair   = ((u + v) % 2 == 1);
            pending_pairs.push_back(p);
         end
      end
      pending_pairs.push_back('{8'd16, 8'd128, 8'd16, 8'd128, 1'b0});
      pending_pairs.push_back('{8'd235, 8'd128, 8'd235, 8'd128, 1'b1});
      pending_pairs.push_back('{8'd255, 8'd255, 8'd0, 8'd0, 1'b1});
      pending_pairs.push_back('{8'd0, 8'd0, 8'd255, 8'd255, 1'b0});
      pending_pairs.push_back('{8'd170, 8'd85, 8'd85, 8'd170, 1'b0});
   endtask

   task automatic wait_drained();
      do begin
         @(negedge clock);
      end while (pending_pairs.size() != 0 || req_valid || expected_pixels.size() != 0);
   endtask

   task automatic check_field(input string field, input pix_type want, input pix_type got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_if.ready) begin
            expected_pixels.push_back(convert_pair(req_pair));
         end
         if (!req_valid || req_if.ready) begin
            if (pending_pairs.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               req_pair  <= pending_pairs.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !long_hold && ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   always @(posedge clock) begin
      bgr_gray_type want;
      if (!reset && rsp_if.valid && rsp_ready) begin
         if (expected_pixels.size() == 0) begin
            $error("unexpected transaction on result channel");
            fail_count++;
         end else begin
            want = expected_pixels.pop_front();
            check_field("blue_first", want.blue_first, rsp_if.blue_first);
            check_field("green_first", want.green_first, rsp_if.green_first);
            check_field("red_first", want.red_first, rsp_if.red_first);
            check_field("blue_second", want.blue_second, rsp_if.blue_second);
            check_field("green_second", want.green_second, rsp_if.green_second);
            check_field("red_second", want.red_second, rsp_if.red_second);
            check_field("gray_first", want.gray_first, rsp_if.gray_first);
            check_field("gray_second", want.gray_second, rsp_if.gray_second);
            check_field("last_out", pix_type'(want.last_out), pix_type'(rsp_if.last_out));
         end
      end
   end

   // hold off the result channel so the pipeline fills and stalls its input
   initial begin
      wait (hold_request);
      long_hold = 1'b1;
      repeat (HoldCycles) @(negedge clock);
      long_hold = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("yuy2_to_rgb_and_gray verification failed");
         $finish;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      queue_directed();
      queue_random(100);
      wait_drained();

      sender_idle_pct = 83;
      queue_random(100);
      wait_drained();

      sender_idle_pct    = 0;
      receiver_stall_pct = 83;
      queue_random(100);
      wait_drained();

      sender_idle_pct    = 19;
      receiver_stall_pct = 19;
      queue_random(100);
      wait_drained();

      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      hold_request       = 1'b1;
      queue_random(80);
      wait_drained();

      queue_random(50);
      wait_drained();
      repeat (DrainCycles) @(negedge clock);

      if (fail_count == 0) begin
         $display("yuy2_to_rgb_and_gray verification clean");
      end else begin
         $display("yuy2_to_rgb_and_gray verification failed");
      end
      $finish;
   end

endmodule
